FILE: src/trht_pkg.sv
package trht_pkg;

   localparam int REGION_SLOTS = 16;
   localparam int SLOT_IDX_W = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
   localparam int SLOT_CNT_W = $clog2(REGION_SLOTS + 1);
   localparam int COORD_W = 16;
   localparam int PROD_W = 2 * COORD_W;

   localparam logic [1:0] KIND_CIRCLE = 2'd0;
   localparam logic [1:0] KIND_RECT   = 2'd1;
   localparam logic [1:0] KIND_GRID   = 2'd2;
   localparam logic [1:0] KIND_NONE   = 2'd3;

   typedef enum logic [1:0] {
      OP_QUERY,
      OP_WRITE,
      OP_DROP
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [SLOT_IDX_W-1:0]   slot;
      logic [1:0]              kind;
      logic                    region_on;
      logic [COORD_W-1:0]      origin_x;
      logic [COORD_W-1:0]      origin_y;
      logic [COORD_W-1:0]      size_a;
      logic [COORD_W-1:0]      size_b;
      logic [COORD_W-1:0]      cells;
      logic [COORD_W-1:0]      touch_x;
      logic [COORD_W-1:0]      touch_y;
   } entry_type;

   typedef struct packed {
      logic                    start;
      logic [COORD_W-1:0]      dividend;
      logic [COORD_W-1:0]      divisor;
   } div_req_type;

endpackage

FILE: src/trht_front.sv
module trht_front
   import trht_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_cmd,
   input  logic [3:0]         req_slot,
   input  logic [1:0]         req_region_kind,
   input  logic               req_region_on,
   input  logic [15:0]        req_origin_x,
   input  logic [15:0]        req_origin_y,
   input  logic [15:0]        req_size_a,
   input  logic [15:0]        req_size_b,
   input  logic [15:0]        req_cells,
   input  logic [15:0]        req_touch_x,
   input  logic [15:0]        req_touch_y,
   output logic               head_valid,
   output entry_type          head,
   input  logic               head_pop
);

   entry_type   queue_ff [2];
   entry_type   entry_in;
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;
   logic        pop;

   // classify the item on the way in
   always_comb begin
      entry_in.op = OP_QUERY;
      if (req_cmd) begin
         if (32'(req_slot) < REGION_SLOTS) begin
            entry_in.op = OP_WRITE;
         end else begin
            entry_in.op = OP_DROP;
         end
      end
      entry_in.slot      = SLOT_IDX_W'(req_slot);
      entry_in.kind      = req_region_kind;
      entry_in.region_on = req_region_on;
      entry_in.origin_x  = req_origin_x;
      entry_in.origin_y  = req_origin_y;
      entry_in.size_a    = req_size_a;
      entry_in.size_b    = req_size_b;
      entry_in.cells     = req_cells;
      entry_in.touch_x   = req_touch_x;
      entry_in.touch_y   = req_touch_y;
   end

   assign req_ready  = (count_ff != 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head       = queue_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready;
   assign pop        = head_pop && head_valid;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

FILE: src/trht_div.sv
module trht_div
   import trht_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  div_req_type        req,
   output logic               done,
   output logic [COORD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(COORD_W);

   logic [COORD_W:0]   rem_ff, rem_in;
   logic [COORD_W-1:0] quo_ff, quo_in;
   logic [COORD_W-1:0] div_ff, div_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [COORD_W:0]   trial;
   logic               take;

   assign trial = {rem_ff[COORD_W-1:0], quo_ff[COORD_W-1]};
   assign take  = trial >= {1'b0, div_ff};

   // one quotient bit a cycle, restoring
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.dividend;
         div_in  = req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = take ? (trial - {1'b0, div_ff}) : trial;
         quo_in = {quo_ff[COORD_W-2:0], take};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(COORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: src/trht_back.sv
module trht_back
   import trht_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  entry_type          head,
   output logic               head_pop,
   output div_req_type        col_req,
   output div_req_type        row_req,
   input  logic               col_done,
   input  logic               row_done,
   input  logic [15:0]        col_quo,
   input  logic [15:0]        row_quo,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_hit,
   output logic [3:0]         rsp_hit_slot,
   output logic               rsp_is_grid,
   output logic [15:0]        rsp_cell_col,
   output logic [15:0]        rsp_cell_row
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SCAN = 6'b000010,
      ST_MUL  = 6'b000100,
      ST_CMP  = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [1:0]         kind_ff   [REGION_SLOTS];
   logic               enable_ff [REGION_SLOTS];
   logic [COORD_W-1:0] ox_ff     [REGION_SLOTS];
   logic [COORD_W-1:0] oy_ff     [REGION_SLOTS];
   logic [COORD_W-1:0] sa_ff     [REGION_SLOTS];
   logic [COORD_W-1:0] sb_ff     [REGION_SLOTS];
   logic [COORD_W-1:0] cells_ff  [REGION_SLOTS];

   logic [SLOT_CNT_W-1:0] scan_ff, scan_in;
   logic [SLOT_IDX_W-1:0] idx;
   logic [COORD_W-1:0]    tx_ff, tx_in, ty_ff, ty_in;
   logic [1:0]            ckind_ff, ckind_in;
   logic [COORD_W-1:0]    dx_ff, dx_in, dy_ff, dy_in;
   logic                  gex_ff, gex_in, gey_ff, gey_in;
   logic [COORD_W-1:0]    csa_ff, csa_in, csb_ff, csb_in, ccells_ff, ccells_in;
   logic [PROD_W-1:0]     pa_ff, pa_in, pb_ff, pb_in, pc_ff, pc_in;
   logic                  hit_ff, hit_in, grid_ff, grid_in;
   logic [3:0]            slot_ff, slot_in;
   logic                  match;
   logic                  table_wr;
   logic                  out_load;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_grid_ff;
   logic [3:0]            rsp_slot_ff;
   logic [COORD_W-1:0]    rsp_col_ff, rsp_row_ff;

   assign idx = scan_ff[SLOT_IDX_W-1:0];

   always_comb begin
      match = 1'b0;
      unique case (ckind_ff)
         KIND_CIRCLE: match = ({1'b0, pa_ff} + {1'b0, pb_ff}) < {1'b0, pc_ff};
         KIND_RECT:   match = gex_ff && gey_ff && (dx_ff <= csa_ff) && (dy_ff <= csb_ff);
         KIND_GRID:   match = gex_ff && gey_ff && (PROD_W'(dx_ff) < pa_ff)
                              && (PROD_W'(dy_ff) < pb_ff);
         KIND_NONE:   match = 1'b0;
         default:     match = 1'b0;
      endcase
   end

   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in  = state_ff;
      scan_in   = scan_ff;
      tx_in     = tx_ff;
      ty_in     = ty_ff;
      ckind_in  = ckind_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      gex_in    = gex_ff;
      gey_in    = gey_ff;
      csa_in    = csa_ff;
      csb_in    = csb_ff;
      ccells_in = ccells_ff;
      pa_in     = pa_ff;
      pb_in     = pb_ff;
      pc_in     = pc_ff;
      hit_in    = hit_ff;
      grid_in   = grid_ff;
      slot_in   = slot_ff;
      head_pop  = 1'b0;
      table_wr  = 1'b0;
      col_req   = '{start: 1'b0, dividend: dx_ff, divisor: csa_ff};
      row_req   = '{start: 1'b0, dividend: dy_ff, divisor: csb_ff};
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               head_pop = 1'b1;
               unique case (head.op)
                  OP_QUERY: begin
                     tx_in    = head.touch_x;
                     ty_in    = head.touch_y;
                     scan_in  = '0;
                     hit_in   = 1'b0;
                     grid_in  = 1'b0;
                     slot_in  = '0;
                     state_in = ST_SCAN;
                  end
                  OP_WRITE: table_wr = 1'b1;
                  OP_DROP:  table_wr = 1'b0;
                  default:  table_wr = 1'b0;
               endcase
            end
         end
         ST_SCAN: begin
            if (32'(scan_ff) >= REGION_SLOTS) begin
               state_in = ST_OUT;
            end else if (enable_ff[idx]) begin
               ckind_in  = kind_ff[idx];
               gex_in    = tx_ff >= ox_ff[idx];
               gey_in    = ty_ff >= oy_ff[idx];
               dx_in     = (tx_ff >= ox_ff[idx]) ? tx_ff - ox_ff[idx] : ox_ff[idx] - tx_ff;
               dy_in     = (ty_ff >= oy_ff[idx]) ? ty_ff - oy_ff[idx] : oy_ff[idx] - ty_ff;
               csa_in    = sa_ff[idx];
               csb_in    = sb_ff[idx];
               ccells_in = cells_ff[idx];
               state_in  = ST_MUL;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_MUL: begin
            if (ckind_ff == KIND_CIRCLE) begin
               pa_in = dx_ff * dx_ff;
               pb_in = dy_ff * dy_ff;
            end else begin
               pa_in = csa_ff * ccells_ff;
               pb_in = csb_ff * ccells_ff;
            end
            pc_in    = csa_ff * csa_ff;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (match) begin
               hit_in  = 1'b1;
               slot_in = 4'(scan_ff);
               if (ckind_ff == KIND_GRID) begin
                  grid_in       = 1'b1;
                  col_req.start = 1'b1;
                  row_req.start = 1'b1;
                  state_in      = ST_DIV;
               end else begin
                  state_in = ST_OUT;
               end
            end else begin
               scan_in  = scan_ff + 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_DIV: begin
            if (col_done && row_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < REGION_SLOTS; i++) begin
            enable_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (table_wr) begin
            enable_ff[head.slot] <= head.region_on;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (table_wr) begin
         kind_ff[head.slot]  <= head.kind;
         ox_ff[head.slot]    <= head.origin_x;
         oy_ff[head.slot]    <= head.origin_y;
         sa_ff[head.slot]    <= head.size_a;
         sb_ff[head.slot]    <= head.size_b;
         cells_ff[head.slot] <= head.cells;
      end
      scan_ff   <= scan_in;
      tx_ff     <= tx_in;
      ty_ff     <= ty_in;
      ckind_ff  <= ckind_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      gex_ff    <= gex_in;
      gey_ff    <= gey_in;
      csa_ff    <= csa_in;
      csb_ff    <= csb_in;
      ccells_ff <= ccells_in;
      pa_ff     <= pa_in;
      pb_ff     <= pb_in;
      pc_ff     <= pc_in;
      hit_ff    <= hit_in;
      grid_ff   <= grid_in;
      slot_ff   <= slot_in;
      if (out_load) begin
         rsp_hit_ff  <= hit_ff;
         rsp_slot_ff <= slot_ff;
         rsp_grid_ff <= grid_ff;
         rsp_col_ff  <= grid_ff ? col_quo : '0;
         rsp_row_ff  <= grid_ff ? row_quo : '0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_hit_slot = rsp_slot_ff;
   assign rsp_is_grid  = rsp_grid_ff;
   assign rsp_cell_col = rsp_col_ff;
   assign rsp_cell_row = rsp_row_ff;

endmodule

FILE: src/touch_region_hit_test.sv
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_ready | cmd, slot, region fields, touch_x/y
// rsp     | out       | rsp_valid / rsp_ready | hit, hit_slot, is_grid, cell_col/row
//
// a write item updates the region table when the back end pops it from the two-item queue
// a query scans the slots in order, skipping disabled ones and taking each enabled one through
// the scan, multiply and compare states; it stops at the first hit, and a grid hit adds shift-subtract division
// synchronous active-high reset clears the queue, the enable bits and the output valid
// the queue keeps taking items while a result waits on rsp_ready, until it is full
module touch_region_hit_test
   import trht_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [3:0]  req_slot,
   input  logic [1:0]  req_region_kind,
   input  logic        req_region_on,
   input  logic [15:0] req_origin_x,
   input  logic [15:0] req_origin_y,
   input  logic [15:0] req_size_a,
   input  logic [15:0] req_size_b,
   input  logic [15:0] req_cells,
   input  logic [15:0] req_touch_x,
   input  logic [15:0] req_touch_y,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_hit,
   output logic [3:0]  rsp_hit_slot,
   output logic        rsp_is_grid,
   output logic [15:0] rsp_cell_col,
   output logic [15:0] rsp_cell_row
);

   logic               head_valid;
   entry_type          head;
   logic               head_pop;
   div_req_type        col_req, row_req;
   logic               col_done, row_done;
   logic [COORD_W-1:0] col_quo, row_quo;

   trht_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_slot        (req_slot),
      .req_region_kind (req_region_kind),
      .req_region_on   (req_region_on),
      .req_origin_x    (req_origin_x),
      .req_origin_y    (req_origin_y),
      .req_size_a      (req_size_a),
      .req_size_b      (req_size_b),
      .req_cells       (req_cells),
      .req_touch_x     (req_touch_x),
      .req_touch_y     (req_touch_y),
      .head_valid      (head_valid),
      .head            (head),
      .head_pop        (head_pop)
   );

   trht_div u_col_div (
      .clock    (clock),
      .reset    (reset),
      .req      (col_req),
      .done     (col_done),
      .quotient (col_quo)
   );

   trht_div u_row_div (
      .clock    (clock),
      .reset    (reset),
      .req      (row_req),
      .done     (row_done),
      .quotient (row_quo)
   );

   trht_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head         (head),
      .head_pop     (head_pop),
      .col_req      (col_req),
      .row_req      (row_req),
      .col_done     (col_done),
      .row_done     (row_done),
      .col_quo      (col_quo),
      .row_quo      (row_quo),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_hit      (rsp_hit),
      .rsp_hit_slot (rsp_hit_slot),
      .rsp_is_grid  (rsp_is_grid),
      .rsp_cell_col (rsp_cell_col),
      .rsp_cell_row (rsp_cell_row)
   );

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> !rsp_is_grid && rsp_hit_slot == 4'd0
         && rsp_cell_col == 16'd0 && rsp_cell_row == 16'd0)
      else $error("miss result carries nonzero fields");

   a_grid_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_grid |-> rsp_hit)
      else $error("grid flag without hit");

   a_div_pair: assert property (@(posedge clock) disable iff (reset)
      col_done == row_done)
      else $error("cell dividers out of step");

   a_reset_out: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule
